// ===== hw/rtl/pnpt_pkg.sv =====
// ----------------------------------------------------------------------------
// pnpt_pkg: shared definitions for the point near polyline test
// Sizes, mode codes, register indexes and multiplier tags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pnpt_pkg;

  localparam int MaxVertices = 256;
  localparam int AddrW       = 8;
  localparam int CountW      = 9;
  localparam int CoordW      = 32;
  localparam int DiamW       = 31;
  localparam int CfgIdxW     = 3;

  localparam logic [1:0] ModeAppend = 2'd0;
  localparam logic [1:0] ModeQuery  = 2'd1;
  localparam logic [1:0] ModeClear  = 2'd2;

  localparam logic [CfgIdxW-1:0] RegDiameter = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMinX     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMaxX     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMinY     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMaxY     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMinZ     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMaxZ     = 3'd6;

  localparam logic [2:0] TagDll = 3'd0;
  localparam logic [2:0] TagDlw = 3'd1;
  localparam logic [2:0] TagErr = 3'd2;
  localparam logic [2:0] TagShh = 3'd3;
  localparam logic [2:0] TagShl = 3'd4;
  localparam logic [2:0] TagSll = 3'd5;
  localparam logic [2:0] TagRhs = 3'd6;

endpackage

// ===== hw/rtl/point_near_polyline_test.sv =====
// ----------------------------------------------------------------------------
// point_near_polyline_test: polyline store with tube hit query
// Appends vertices to a memory and tests query points against the tube.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i/in_stall_o) carries one request of
// mode, coord_x, coord_y, coord_z. Append writes a vertex, clear empties the
// store, query tests the point. Each request yields one result on the output
// channel (out_valid_o/out_stall_i): hit, status, vertex_count.
// Append, clear and unused mode answer in the cycle after acceptance. A query
// that fails the box check or finds fewer than two vertices goes straight to
// the done state; otherwise it walks the segments one at a time through one
// shared 34x34 multiplier and a bit-serial divider (reads, dot products,
// divide, offset, squares, compare, advance; a zero-length segment goes from
// the dot products straight to the advance), up to 255 segments a query.
// A new request is taken only while the sequencer is idle and the output
// register is free or being drained. A stalled result holds.
// Reset empties the store and loads diameter 1.0 and an empty box; no
// clearing pass runs. Configuration writes (cfg_valid_i/cfg_ready_o) are
// always taken; an index past the list is ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_near_polyline_test (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         mode_i,
  input  logic signed [pnpt_pkg::CoordW-1:0] coord_x_i,
  input  logic signed [pnpt_pkg::CoordW-1:0] coord_y_i,
  input  logic signed [pnpt_pkg::CoordW-1:0] coord_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               hit_o,
  output logic                               status_o,
  output logic [pnpt_pkg::CountW-1:0]        vertex_count_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pnpt_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [31:0]                        cfg_data_i
);
  import pnpt_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RA   = 4'd1;
  localparam logic [3:0] S_RB   = 4'd2;
  localparam logic [3:0] S_LW   = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_DRN  = 4'd5;
  localparam logic [3:0] S_DIV0 = 4'd6;
  localparam logic [3:0] S_DIVI = 4'd7;
  localparam logic [3:0] S_CMP  = 4'd8;
  localparam logic [3:0] S_NEXT = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  localparam logic [1:0] PH_DOT = 2'd0;
  localparam logic [1:0] PH_T   = 2'd1;
  localparam logic [1:0] PH_ERR = 2'd2;

  logic [3:0]  state_q;
  logic [1:0]  phase_q;
  logic [3:0]  k_q;
  logic [4:0]  j_q;
  logic [CountW-1:0] count_q, idx_q;

  logic [DiamW-1:0]         diam_q;
  logic signed [CoordW-1:0] bmin_q [3];
  logic signed [CoordW-1:0] bmax_q [3];

  logic [3*CoordW-1:0] mem [MaxVertices];
  logic [3*CoordW-1:0] rdata_q;
  logic [AddrW-1:0]    raddr;

  logic signed [CoordW-1:0] p_q [3];
  logic signed [CoordW-1:0] a_q [3];
  logic signed [CoordW:0]   l_q [3];
  logic signed [CoordW:0]   w_q [3];
  logic signed [51:0]       e_q [3];

  logic [67:0]         dll_q, rem_q;
  logic signed [67:0]  dlw_q;
  logic [16:0]         t_q;
  logic [103:0]        sum_q;
  logic [95:0]         rhs_q;

  logic signed [33:0] opa, opb;
  logic [2:0]         tag;
  logic [1:0]         tax;
  logic signed [67:0] prod_q;
  logic [2:0]         ptag_q;
  logic [1:0]         pax_q;
  logic               pv_q;

  logic        out_valid_q, hit_q, status_q;
  logic [CountW-1:0] vcount_q;

  logic        accept, out_free, out_load, in_box, last_k;
  logic [50:0] me;
  logic signed [51:0] esel;
  logic [67:0] rem2;
  logic [CoordW-1:0] bx, by, bz;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_load   = (accept && mode_i != ModeQuery) || (state_q == S_DONE && out_free);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign hit_o = hit_q;
  assign status_o = status_q;
  assign vertex_count_o = vcount_q;

  assign in_box = (coord_x_i > bmin_q[0]) && (coord_x_i < bmax_q[0]) &&
                  (coord_y_i > bmin_q[1]) && (coord_y_i < bmax_q[1]) &&
                  (coord_z_i > bmin_q[2]) && (coord_z_i < bmax_q[2]);

  assign rem2 = {rem_q[66:0], 1'b0};
  assign {bz, by, bx} = rdata_q;

  always_comb begin
    raddr = (state_q == S_RA) ? 8'(idx_q - 9'd1) : idx_q[AddrW-1:0];
  end

  // operand selection for the shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    tag = TagDll;
    tax = 2'd0;
    last_k = 1'b0;
    esel = e_q[0];
    case (phase_q)
      PH_DOT: begin
        tax = k_q[2:1];
        opa = {l_q[tax][CoordW], l_q[tax]};
        opb = k_q[0] ? {w_q[tax][CoordW], w_q[tax]} : {l_q[tax][CoordW], l_q[tax]};
        tag = k_q[0] ? TagDlw : TagDll;
        last_k = (k_q == 4'd5);
      end
      PH_T: begin
        tax = k_q[1:0];
        opa = {17'd0, t_q};
        opb = {l_q[tax][CoordW], l_q[tax]};
        tag = TagErr;
        last_k = (k_q == 4'd2);
      end
      default: begin
        tax = (k_q < 4'd3) ? 2'd0 : (k_q < 4'd6) ? 2'd1 : 2'd2;
        esel = e_q[tax];
        last_k = (k_q == 4'd9);
        if (k_q == 4'd9) begin
          opa = {3'd0, diam_q};
          opb = {3'd0, diam_q};
          tag = TagRhs;
        end else begin
          case (4'(k_q - {tax, 1'b0} - {2'd0, tax}))
            4'd0: begin
              opa = {9'd0, me[50:26]};
              opb = {9'd0, me[50:26]};
              tag = TagShh;
            end
            4'd1: begin
              opa = {9'd0, me[50:26]};
              opb = {8'd0, me[25:0]};
              tag = TagShl;
            end
            default: begin
              opa = {8'd0, me[25:0]};
              opb = {8'd0, me[25:0]};
              tag = TagSll;
            end
          endcase
        end
      end
    endcase
  end

  assign me = esel[51] ? 51'(-esel) : esel[50:0];

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && accept && mode_i == ModeAppend &&
        count_q < CountW'(MaxVertices)) begin
      mem[count_q[AddrW-1:0]] <= {coord_z_i, coord_y_i, coord_x_i};
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
    ptag_q <= tag;
    pax_q  <= tax;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diam_q <= DiamW'(65536);
      for (int i = 0; i < 3; i++) begin
        bmin_q[i] <= '0;
        bmax_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDiameter: diam_q <= cfg_data_i[DiamW-1:0];
        RegMinX: bmin_q[0] <= cfg_data_i;
        RegMaxX: bmax_q[0] <= cfg_data_i;
        RegMinY: bmin_q[1] <= cfg_data_i;
        RegMaxY: bmax_q[1] <= cfg_data_i;
        RegMinZ: bmin_q[2] <= cfg_data_i;
        RegMaxZ: bmax_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // accumulate the registered product
  always_ff @(posedge clk_i) begin
    if (state_q == S_LW) begin
      dll_q <= '0;
      dlw_q <= '0;
    end else if (state_q == S_DRN && phase_q == PH_T) begin
      sum_q <= '0;
    end
    if (pv_q) begin
      case (ptag_q)
        TagDll: dll_q <= dll_q + prod_q;
        TagDlw: dlw_q <= dlw_q + prod_q;
        TagErr: e_q[pax_q] <= {{3{w_q[pax_q][CoordW]}}, w_q[pax_q], 16'h0} - prod_q[51:0];
        TagShh: sum_q <= sum_q + ({36'd0, prod_q} << 52);
        TagShl: sum_q <= sum_q + ({36'd0, prod_q} << 27);
        TagSll: sum_q <= sum_q + {36'd0, prod_q};
        default: rhs_q <= {prod_q[63:0], 32'd0};
      endcase
    end
    if (state_q == S_RB) begin
      a_q[0] <= bx;
      a_q[1] <= by;
      a_q[2] <= bz;
    end
    if (state_q == S_LW) begin
      l_q[0] <= {bx[CoordW-1], bx} - {a_q[0][CoordW-1], a_q[0]};
      l_q[1] <= {by[CoordW-1], by} - {a_q[1][CoordW-1], a_q[1]};
      l_q[2] <= {bz[CoordW-1], bz} - {a_q[2][CoordW-1], a_q[2]};
      for (int i = 0; i < 3; i++) begin
        w_q[i] <= {p_q[i][CoordW-1], p_q[i]} - {a_q[i][CoordW-1], a_q[i]};
      end
    end
    if (state_q == S_IDLE && accept) begin
      p_q[0] <= coord_x_i;
      p_q[1] <= coord_y_i;
      p_q[2] <= coord_z_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_DOT;
      k_q <= '0;
      j_q <= '0;
      count_q <= '0;
      idx_q <= '0;
      pv_q <= 1'b0;
      t_q <= '0;
      rem_q <= '0;
      out_valid_q <= 1'b0;
      hit_q <= 1'b0;
      status_q <= 1'b0;
      vcount_q <= '0;
    end else begin
      pv_q <= 1'b0;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            hit_q <= 1'b0;
            status_q <= (mode_i == ModeAppend) && (count_q == CountW'(MaxVertices));
            idx_q <= CountW'(1);
            if (mode_i == ModeQuery) begin
              if (count_q > CountW'(1) && in_box) state_q <= S_RA;
              else state_q <= S_DONE;
            end else if (mode_i == ModeAppend && count_q < CountW'(MaxVertices)) begin
              count_q <= count_q + 9'd1;
              vcount_q <= count_q + 9'd1;
            end else if (mode_i == ModeClear) begin
              count_q <= '0;
              vcount_q <= '0;
            end else begin
              vcount_q <= count_q;
            end
          end
        end
        S_RA: state_q <= S_RB;
        S_RB: state_q <= S_LW;
        S_LW: begin
          phase_q <= PH_DOT;
          k_q <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          pv_q <= 1'b1;
          k_q <= k_q + 4'd1;
          if (last_k) state_q <= S_DRN;
        end
        S_DRN: begin
          k_q <= '0;
          case (phase_q)
            PH_DOT: state_q <= S_DIV0;
            PH_T: begin
              phase_q <= PH_ERR;
              state_q <= S_MUL;
            end
            default: state_q <= S_CMP;
          endcase
        end
        S_DIV0: begin
          phase_q <= PH_T;
          j_q <= '0;
          if (dll_q == '0) begin
            state_q <= S_NEXT;
          end else if (dlw_q[67] || dlw_q == '0) begin
            t_q <= '0;
            state_q <= S_MUL;
          end else if (dlw_q >= dll_q) begin
            t_q <= 17'h10000;
            state_q <= S_MUL;
          end else begin
            t_q <= '0;
            rem_q <= dlw_q;
            state_q <= S_DIVI;
          end
        end
        S_DIVI: begin
          if (rem2 >= dll_q) begin
            rem_q <= rem2 - dll_q;
            t_q <= {t_q[15:0], 1'b1};
          end else begin
            rem_q <= rem2;
            t_q <= {t_q[15:0], 1'b0};
          end
          j_q <= j_q + 5'd1;
          if (j_q == 5'd15) state_q <= S_MUL;
        end
        S_CMP: begin
          if ({sum_q, 2'b00} < {10'd0, rhs_q}) begin
            hit_q <= 1'b1;
            state_q <= S_DONE;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          idx_q <= idx_q + 9'd1;
          if (idx_q + 9'd1 < count_q) state_q <= S_RA;
          else state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            vcount_q <= count_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxVertices)) else $error("vertex count overflow");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (vertex_count_o == CountW'(MaxVertices)))
    else $error("drop flagged below full");

  a_div_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVI) |-> (j_q < 5'd16)) else $error("divider overrun");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |=> in_stall_o) else $error("request taken mid query");

endmodule

// ===== bench/point_near_polyline_test_tb.sv =====
// ----------------------------------------------------------------------------
// point_near_polyline_test_tb: self-checking bench for the polyline tube test
// Appends polylines, clears them and queries points near and far from the
// segments under several box and diameter settings. Every request is
// predicted with exact wide integer math and checked against the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_near_polyline_test_tb;
  import pnpt_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam logic [1:0]         ModeNop   = 2'd3;
  localparam int                 IdleLimit = 100000;
  localparam int                 MinCoord  = -2147483647 - 1;
  localparam int                 MaxCoord  = 2147483647;

  typedef struct {
    logic [1:0]               mode;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } request_t;

  typedef struct {
    logic              hit;
    logic              status;
    logic [CountW-1:0] count;
  } outcome_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_stall_o;
  logic [1:0]           mode;
  logic signed [31:0]   coord_x, coord_y, coord_z;
  logic                 out_valid_o;
  logic                 out_stall;
  logic                 hit_o;
  logic                 status_o;
  logic [CountW-1:0]    vertex_count_o;
  logic                 cfg_valid;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [31:0]          cfg_data;

  point_near_polyline_test uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall_o),
    .mode_i(mode), .coord_x_i(coord_x), .coord_y_i(coord_y), .coord_z_i(coord_z),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall),
    .hit_o(hit_o), .status_o(status_o), .vertex_count_o(vertex_count_o),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // shadow state of the block
  logic signed [31:0] vx [MaxVertices];
  logic signed [31:0] vy [MaxVertices];
  logic signed [31:0] vz [MaxVertices];
  int                 held;
  logic [DiamW-1:0]   diam;
  logic signed [31:0] bmin_x, bmax_x, bmin_y, bmax_y, bmin_z, bmax_z;

  request_t pending_requests[$];
  outcome_t expected_results[$];
  request_t cur;
  int       gap;
  bit       burst;
  int       errors, results_seen, stall_cnt, idle_cycles, pushed;
  int       n_queries, n_hits, n_drops;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit seg_within_tube(int ia, int ib, logic signed [31:0] px,
                                         logic signed [31:0] py, logic signed [31:0] pz);
    logic signed [127:0] lx, ly, lz, wx, wy, wz, ex, ey, ez, dll, dlw, t, sum, rhs, d;
    lx = vx[ib] - vx[ia]; ly = vy[ib] - vy[ia]; lz = vz[ib] - vz[ia];
    wx = px - vx[ia];     wy = py - vy[ia];     wz = pz - vz[ia];
    dll = lx * lx + ly * ly + lz * lz;
    dlw = lx * wx + ly * wy + lz * wz;
    if (dll == 0) return 1'b0;
    if (dlw <= 0) t = 0;
    else if (dlw >= dll) t = 65536;
    else t = (dlw <<< 16) / dll;
    ex = wx * 65536 - t * lx;
    ey = wy * 65536 - t * ly;
    ez = wz * 65536 - t * lz;
    sum = (ex * ex + ey * ey + ez * ez) * 4;
    d = {97'd0, diam};
    rhs = (d * d) <<< 32;
    return sum < rhs;
  endfunction

  function automatic outcome_t tube_predict(request_t r);
    outcome_t o;
    o.hit = 1'b0;
    o.status = 1'b0;
    case (r.mode)
      ModeAppend: begin
        if (held < MaxVertices) begin
          vx[held] = r.x; vy[held] = r.y; vz[held] = r.z;
          held++;
        end else begin
          o.status = 1'b1;
        end
      end
      ModeQuery: begin
        if (held > 0 && r.x > bmin_x && r.x < bmax_x && r.y > bmin_y && r.y < bmax_y &&
            r.z > bmin_z && r.z < bmax_z) begin
          for (int i = 1; i < held; i++) begin
            if (seg_within_tube(i - 1, i, r.x, r.y, r.z)) begin
              o.hit = 1'b1;
              break;
            end
          end
        end
      end
      ModeClear: held = 0;
      default: ;
    endcase
    o.count = held[CountW-1:0];
    return o;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      mode <= ModeAppend;
      coord_x <= '0; coord_y <= '0; coord_z <= '0;
      gap = 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        expected_results.insert(expected_results.size(), tube_predict(cur));
        if (cur.mode == ModeQuery) n_queries++;
      end
      if (!in_valid || !in_stall_o) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          cur = pending_requests.pop_front();
          mode <= cur.mode;
          coord_x <= cur.x; coord_y <= cur.y; coord_z <= cur.z;
          in_valid <= 1'b1;
          gap = burst ? 0 : $urandom_range(0, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t e;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result hit=%0d status=%0d count=%0d",
                                     hit_o, status_o, vertex_count_o);
        end else begin
          e = expected_results.pop_front();
          if (e.hit) n_hits++;
          if (e.status) n_drops++;
          if (hit_o !== e.hit || status_o !== e.status || vertex_count_o !== e.count) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected hit=%0d status=%0d count=%0d, got %0d %0d %0d",
                       e.hit, e.status, e.count, hit_o, status_o, vertex_count_o);
          end
        end
        stall_cnt = burst ? 0 : $urandom_range(0, 11);
        if (results_seen == 300) stall_cnt = 600;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
      end
      out_stall <= (stall_cnt > 0);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send(logic [1:0] m, logic signed [31:0] x, logic signed [31:0] y,
                      logic signed [31:0] z);
    request_t r;
    r.mode = m; r.x = x; r.y = y; r.z = z;
    pending_requests.insert(pending_requests.size(), r);
    pushed++;
  endtask

  task automatic wait_idle();
    wait (pending_requests.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegDiameter: diam = data[DiamW-1:0];
      RegMinX: bmin_x = data;
      RegMaxX: bmax_x = data;
      RegMinY: bmin_y = data;
      RegMaxY: bmax_y = data;
      RegMinZ: bmin_z = data;
      RegMaxZ: bmax_z = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_box(logic signed [31:0] lo, logic signed [31:0] hi);
    write_reg(RegMinX, lo); write_reg(RegMaxX, hi);
    write_reg(RegMinY, lo); write_reg(RegMaxY, hi);
    write_reg(RegMinZ, lo); write_reg(RegMaxZ, hi);
  endtask

  function automatic logic signed [31:0] jitter(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // a clear (or at times a nop), a polyline of n vertices and nq requests, mostly queries near it
  task automatic random_polyline(int n, int nq, int step, int span,
                                 logic signed [31:0] base);
    logic signed [31:0] px [MaxVertices + 4];
    logic signed [31:0] py [MaxVertices + 4];
    logic signed [31:0] pz [MaxVertices + 4];
    int k;
    if ($urandom_range(0, 9) != 0) send(ModeClear, $urandom, $urandom, $urandom);
    else send(ModeNop, $urandom, $urandom, $urandom);
    px[0] = base + jitter(step); py[0] = base + jitter(step); pz[0] = base + jitter(step);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && i < MaxVertices + 4) begin
        if ($urandom_range(0, 15) == 0) begin
          px[i] = px[i - 1]; py[i] = py[i - 1]; pz[i] = pz[i - 1];
        end else begin
          px[i] = px[i - 1] + jitter(step);
          py[i] = py[i - 1] + jitter(step);
          pz[i] = pz[i - 1] + jitter(step);
        end
      end
      if ($urandom_range(0, 30) == 0) send(ModeAppend, $urandom, $urandom, $urandom);
      else send(ModeAppend, px[i], py[i], pz[i]);
    end
    for (int q = 0; q < nq; q++) begin
      k = (n > 0) ? $urandom_range(0, n - 1) : 0;
      case ($urandom_range(0, 9))
        0: send(ModeQuery, $urandom, $urandom, $urandom);
        1: send(ModeNop, $urandom, $urandom, $urandom);
        default: send(ModeQuery, px[k] + jitter(span), py[k] + jitter(span),
                      pz[k] + jitter(span));
      endcase
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    burst = 1'b0;
    errors = 0; results_seen = 0; pushed = 0;
    n_queries = 0; n_hits = 0; n_drops = 0;
    held = 0;
    diam = 31'd65536;
    bmin_x = 0; bmax_x = 0; bmin_y = 0; bmax_y = 0; bmin_z = 0; bmax_z = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset box is empty: nothing can hit
    send(ModeQuery, 0, 0, 0);
    send(ModeAppend, 0, 0, 0);
    send(ModeAppend, 65536, 0, 0);
    send(ModeQuery, 0, 0, 0);
    send(ModeNop, MinCoord, MaxCoord, -1);
    wait_idle();

    set_box(MinCoord, MaxCoord);
    write_reg(RegDiameter, 32'hFFFF_FFFF);
    write_reg(RegUnused, 32'h1234_5678);
    send(ModeClear, 0, 0, 0);
    send(ModeQuery, 1, 1, 1);
    send(ModeAppend, 5, 5, 5);
    send(ModeQuery, 5, 5, 5);
    send(ModeAppend, 5, 5, 5);
    send(ModeQuery, 5, 5, 5);
    send(ModeAppend, MinCoord, MinCoord, MinCoord);
    send(ModeAppend, MaxCoord, MaxCoord, MaxCoord);
    send(ModeQuery, MinCoord, MinCoord, MinCoord);
    send(ModeQuery, MinCoord + 1, MinCoord + 1, MinCoord + 1);
    send(ModeQuery, MaxCoord - 1, MaxCoord - 1, MaxCoord - 1);
    send(ModeQuery, 0, 0, 0);
    send(ModeQuery, MaxCoord - 1, MinCoord + 1, 0);
    send(ModeClear, -1, -1, -1);
    wait_idle();

    write_reg(RegDiameter, 0);
    send(ModeAppend, 0, 0, 0);
    send(ModeAppend, 65536, 0, 0);
    send(ModeQuery, 32768, 0, 0);
    wait_idle();

    // fill the store past its end, then walk every segment
    write_reg(RegDiameter, 65536);
    random_polyline(MaxVertices + 3, 0, 1 << 18, 0, 0);
    send(ModeQuery, MaxCoord - 1, MaxCoord - 1, MaxCoord - 1);
    send(ModeQuery, 0, 0, 0);
    wait_idle();

    while (pushed < 1450) begin
      case ($urandom_range(0, 5))
        0: write_reg(RegDiameter, 65536);
        1: write_reg(RegDiameter, $urandom_range(1 << 16, 1 << 22));
        2: write_reg(RegDiameter, {1'b0, 31'h7FFF_FFFF});
        3: write_reg(RegDiameter, $urandom);
        4: write_reg(RegDiameter, $urandom_range(0, 3));
        default: write_reg(RegDiameter, $urandom_range(1 << 10, 1 << 16));
      endcase
      if ($urandom_range(0, 5) == 0) set_box(-(1 << 22), 1 << 22);
      else set_box(MinCoord, MaxCoord);
      burst = ($urandom_range(0, 3) == 0);
      for (int s = 0; s < 6; s++)
        random_polyline($urandom_range(0, 12), $urandom_range(2, 10), 1 << 16,
                        (diam > 64) ? diam : 64, ($urandom_range(0, 3) == 0) ? $urandom : 0);
      wait_idle();
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    $display("covered %0d requests, %0d queries with %0d hits, %0d appends dropped as full",
             pushed, n_queries, n_hits, n_drops);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
